/* hw/rtl/gdt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdt_pkg
// Types and constants for the gray double threshold unit: pixel words,
// configuration word, register indexes, luma weights and marking colors.
// ----------------------------------------------------------------------------
package gdt_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 8;

  // Luma weights in Q14; they sum to exactly 1 << 14.
  localparam int unsigned GrayShift = 14;
  localparam int unsigned AccW      = 23;
  localparam logic [AccW-1:0] CoefB     = AccW'(1868);
  localparam logic [AccW-1:0] CoefG     = AccW'(9617);
  localparam logic [AccW-1:0] CoefR     = AccW'(4899);
  localparam logic [AccW-1:0] GrayRound = AccW'(8192);

  localparam logic [ChanW-1:0] ChanMax  = 8'hff;
  localparam logic [ChanW-1:0] ChanZero = 8'h00;

  typedef enum logic [CfgIndexW-1:0] {
    CfgLowThreshold  = 3'd0,
    CfgHighThreshold = 3'd1,
    CfgMarkLowColor  = 3'd2,
    CfgMarkHighColor = 3'd3,
    CfgPreviewMode   = 3'd4,
    CfgGrayInput     = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic [ChanW-1:0] in_blue;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_red;
  } in_word_t;

  typedef struct packed {
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_red;
  } out_word_t;

  typedef struct packed {
    logic [ChanW-1:0] low_threshold;
    logic [ChanW-1:0] high_threshold;
    logic             mark_low_color;
    logic             mark_high_color;
    logic             preview_mode;
    logic             gray_input;
  } cfg_t;

endpackage : gdt_pkg
`default_nettype wire

/* hw/rtl/gray_double_threshold_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gray_double_threshold_unit
// Converts a BGR pixel (or a ready gray level) to luma and clips it against
// a low and a high threshold, with optional color marking for preview.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_data_i         | to unit
//  out     | out_valid_o, out_stall_i, out_data_o      | from unit
//  cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i        | to unit
//
//  One word is accepted per cycle while the input does not stall; each word
//  passes through the input register and then the result register.
//  Reset clears the valid flags and loads the register defaults.
//  A stall at the output holds the result; the input stalls only when both
//  the input register and the result register are full and the output stalls.
// ----------------------------------------------------------------------------
module gray_double_threshold_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire gdt_pkg::in_word_t             in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output gdt_pkg::out_word_t                 out_data_o,
  input  wire                                cfg_we_i,
  input  wire [gdt_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  wire [gdt_pkg::CfgDataW-1:0]        cfg_wdata_i
);

  gdt_pkg::cfg_t      cfg_q;
  gdt_pkg::in_word_t  pix_q;
  logic               pix_valid_q;
  gdt_pkg::out_word_t res_d;
  gdt_pkg::out_word_t res_q;
  logic               res_valid_q;
  logic               res_free;
  logic               pix_free;

  assign res_free   = !res_valid_q || !out_stall_i;
  assign pix_free   = !pix_valid_q || res_free;
  assign in_stall_o = !pix_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold   <= gdt_pkg::ChanZero;
      cfg_q.high_threshold  <= gdt_pkg::ChanMax;
      cfg_q.mark_low_color  <= 1'b0;
      cfg_q.mark_high_color <= 1'b0;
      cfg_q.preview_mode    <= 1'b0;
      cfg_q.gray_input      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (gdt_pkg::cfg_index_e'(cfg_index_i))
        gdt_pkg::CfgLowThreshold:  cfg_q.low_threshold   <= cfg_wdata_i;
        gdt_pkg::CfgHighThreshold: cfg_q.high_threshold  <= cfg_wdata_i;
        gdt_pkg::CfgMarkLowColor:  cfg_q.mark_low_color  <= cfg_wdata_i[0];
        gdt_pkg::CfgMarkHighColor: cfg_q.mark_high_color <= cfg_wdata_i[0];
        gdt_pkg::CfgPreviewMode:   cfg_q.preview_mode    <= cfg_wdata_i[0];
        gdt_pkg::CfgGrayInput:     cfg_q.gray_input      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (pix_free) begin
        pix_valid_q <= in_valid_i;
      end
      if (res_free) begin
        res_valid_q <= pix_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_free && in_valid_i) begin
      pix_q <= in_data_i;
    end
    if (res_free && pix_valid_q) begin
      res_q <= res_d;
    end
  end

  gdt_core u_core (
    .pix_i (pix_q),
    .cfg_i (cfg_q),
    .pix_o (res_d)
  );

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  // The input stalls only with a word waiting in the input register.
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pix_valid_q)
    else $error("input stalled with an empty input register");

  // A word in the input register moves to the result register when it is free.
  a_word_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_q && res_free) |=> res_valid_q)
    else $error("word lost between input and result register");

  // The result only drops after it was taken.
  a_result_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(res_valid_q) |-> $past(!out_stall_i))
    else $error("result dropped while stalled");

  // A full pipeline with a stalled output must hold off the input.
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_q && res_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input accepted into a full pipeline");

endmodule : gray_double_threshold_unit
`default_nettype wire

/* hw/rtl/gdt_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdt_core
// Combinational datapath: luma conversion, threshold ordering and the
// low / high / pass-through decision for one pixel.
// ----------------------------------------------------------------------------
module gdt_core (
  input  wire gdt_pkg::in_word_t  pix_i,
  input  wire gdt_pkg::cfg_t      cfg_i,
  output gdt_pkg::out_word_t pix_o
);

  logic [gdt_pkg::AccW-1:0]  acc;
  logic [gdt_pkg::AccW-gdt_pkg::GrayShift-1:0] luma_wide;
  logic [gdt_pkg::ChanW-1:0] luma;
  logic [gdt_pkg::ChanW-1:0] level;
  logic [gdt_pkg::ChanW-1:0] lo_thr;
  logic [gdt_pkg::ChanW-1:0] hi_thr;

  assign acc = gdt_pkg::CoefB * gdt_pkg::AccW'(pix_i.in_blue)
             + gdt_pkg::CoefG * gdt_pkg::AccW'(pix_i.in_green)
             + gdt_pkg::CoefR * gdt_pkg::AccW'(pix_i.in_red)
             + gdt_pkg::GrayRound;

  assign luma_wide = acc[gdt_pkg::AccW-1:gdt_pkg::GrayShift];

  // The weights sum to one, so the clamp never fires; it is kept as a guard.
  assign luma  = luma_wide[gdt_pkg::ChanW] ? gdt_pkg::ChanMax
                                           : luma_wide[gdt_pkg::ChanW-1:0];
  assign level = cfg_i.gray_input ? pix_i.in_blue : luma;

  // Reversed thresholds are swapped so that lo_thr never exceeds hi_thr.
  assign lo_thr = (cfg_i.low_threshold > cfg_i.high_threshold) ?
                  cfg_i.high_threshold : cfg_i.low_threshold;
  assign hi_thr = (cfg_i.low_threshold > cfg_i.high_threshold) ?
                  cfg_i.low_threshold : cfg_i.high_threshold;

  always_comb begin
    priority if (level <= lo_thr) begin
      // Yellow marking in preview, black otherwise.
      pix_o.out_blue = gdt_pkg::ChanZero;
      if (cfg_i.preview_mode && cfg_i.mark_low_color) begin
        pix_o.out_green = gdt_pkg::ChanMax;
        pix_o.out_red   = gdt_pkg::ChanMax;
      end else begin
        pix_o.out_green = gdt_pkg::ChanZero;
        pix_o.out_red   = gdt_pkg::ChanZero;
      end
    end else if (level >= hi_thr) begin
      // Red marking in preview, white otherwise.
      pix_o.out_red = gdt_pkg::ChanMax;
      if (cfg_i.preview_mode && cfg_i.mark_high_color) begin
        pix_o.out_blue  = gdt_pkg::ChanZero;
        pix_o.out_green = gdt_pkg::ChanZero;
      end else begin
        pix_o.out_blue  = gdt_pkg::ChanMax;
        pix_o.out_green = gdt_pkg::ChanMax;
      end
    end else begin
      pix_o.out_blue  = level;
      pix_o.out_green = level;
      pix_o.out_red   = level;
    end
  end

endmodule : gdt_core
`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gray_double_threshold_unit. Pixel words are sent
// with random gaps while the output side stalls at random. A scoreboard
// predicts every accepted word from its own copy of the registers, and it
// checks each delivered word in order. Directed pixels hit the threshold
// corners first, then randomized settings and pixels follow.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SegmentWords = 23;
  localparam int unsigned SegmentCount = 8;
  localparam int unsigned DrainCycles  = 8;
  localparam logic [gdt_pkg::CfgIndexW-1:0] UnusedIndexA = 3'd6;
  localparam logic [gdt_pkg::CfgIndexW-1:0] UnusedIndexB = 3'd7;

  class pixel_scoreboard;
    gdt_pkg::out_word_t expected_q[$];
    gdt_pkg::cfg_t      cfg;
    int                 errors;

    function new();
      cfg = '{low_threshold: gdt_pkg::ChanZero, high_threshold: gdt_pkg::ChanMax,
              default: 1'b0};
      errors = 0;
    endfunction

    // Register writes are masked to the width of the register they hit.
    function void set_reg(logic [gdt_pkg::CfgIndexW-1:0] index,
                          logic [gdt_pkg::CfgDataW-1:0] wdata);
      unique case (index)
        gdt_pkg::CfgLowThreshold:  cfg.low_threshold   = wdata;
        gdt_pkg::CfgHighThreshold: cfg.high_threshold  = wdata;
        gdt_pkg::CfgMarkLowColor:  cfg.mark_low_color  = wdata[0];
        gdt_pkg::CfgMarkHighColor: cfg.mark_high_color = wdata[0];
        gdt_pkg::CfgPreviewMode:   cfg.preview_mode    = wdata[0];
        gdt_pkg::CfgGrayInput:     cfg.gray_input      = wdata[0];
        default: ;
      endcase
    endfunction

    function gdt_pkg::out_word_t clip_pixel(gdt_pkg::in_word_t px);
      logic [gdt_pkg::AccW-1:0]  acc;
      logic [gdt_pkg::ChanW-1:0] lum;
      logic [gdt_pkg::ChanW-1:0] lo;
      logic [gdt_pkg::ChanW-1:0] hi;
      gdt_pkg::out_word_t        res;
      acc = gdt_pkg::CoefB * px.in_blue + gdt_pkg::CoefG * px.in_green
          + gdt_pkg::CoefR * px.in_red + gdt_pkg::GrayRound;
      lum = cfg.gray_input ? px.in_blue : acc[gdt_pkg::GrayShift +: gdt_pkg::ChanW];
      lo  = cfg.low_threshold;
      hi  = cfg.high_threshold;
      if (lo > hi) begin
        lo = cfg.high_threshold;
        hi = cfg.low_threshold;
      end
      // The low test is applied first, so it wins when both hold.
      if (lum <= lo) begin
        if (cfg.preview_mode && cfg.mark_low_color) begin
          res = '{out_blue: gdt_pkg::ChanZero, out_green: gdt_pkg::ChanMax,
                  out_red: gdt_pkg::ChanMax};
        end else begin
          res = '{out_blue: gdt_pkg::ChanZero, out_green: gdt_pkg::ChanZero,
                  out_red: gdt_pkg::ChanZero};
        end
      end else if (lum >= hi) begin
        if (cfg.preview_mode && cfg.mark_high_color) begin
          res = '{out_blue: gdt_pkg::ChanZero, out_green: gdt_pkg::ChanZero,
                  out_red: gdt_pkg::ChanMax};
        end else begin
          res = '{out_blue: gdt_pkg::ChanMax, out_green: gdt_pkg::ChanMax,
                  out_red: gdt_pkg::ChanMax};
        end
      end else begin
        res = '{out_blue: lum, out_green: lum, out_red: lum};
      end
      return res;
    endfunction

    function void note_input(gdt_pkg::in_word_t px);
      expected_q = {expected_q, clip_pixel(px)};
    endfunction

    function void check_result(gdt_pkg::out_word_t got);
      gdt_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected output word %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.out_blue !== want.out_blue) begin
        $error("out_blue: expected %0d, got %0d", want.out_blue, got.out_blue);
        errors++;
      end
      if (got.out_green !== want.out_green) begin
        $error("out_green: expected %0d, got %0d", want.out_green, got.out_green);
        errors++;
      end
      if (got.out_red !== want.out_red) begin
        $error("out_red: expected %0d, got %0d", want.out_red, got.out_red);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  gdt_pkg::in_word_t             in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  gdt_pkg::out_word_t            out_data_o;
  logic                          cfg_we_i    = 1'b0;
  logic [gdt_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [gdt_pkg::CfgDataW-1:0]  cfg_wdata_i = '0;

  pixel_scoreboard sb = new();
  int unsigned src_idle_pct = 28;
  int unsigned dst_stall_pct = 59;
  int unsigned cycle_count = 0;

  gray_double_threshold_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < dst_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic gdt_pkg::in_word_t mk_px(logic [gdt_pkg::ChanW-1:0] b,
                                              logic [gdt_pkg::ChanW-1:0] g,
                                              logic [gdt_pkg::ChanW-1:0] r);
    return '{in_blue: b, in_green: g, in_red: r};
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_pixel(input gdt_pkg::in_word_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // The first edge lets the monitor record a word taken at the current edge.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gdt_pkg::CfgIndexW-1:0] index,
                           input logic [gdt_pkg::CfgDataW-1:0] wdata);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= wdata;
    sb.set_reg(index, wdata);
    @(posedge clk_i);
  endtask

  // Single-bit registers get random upper bits, which the unit must drop.
  task automatic apply_cfg(input gdt_pkg::cfg_t c, input bit poke_unused);
    write_reg(gdt_pkg::CfgLowThreshold, c.low_threshold);
    write_reg(gdt_pkg::CfgHighThreshold, c.high_threshold);
    write_reg(gdt_pkg::CfgMarkLowColor, {7'($urandom), c.mark_low_color});
    write_reg(gdt_pkg::CfgMarkHighColor, {7'($urandom), c.mark_high_color});
    write_reg(gdt_pkg::CfgPreviewMode, {7'($urandom), c.preview_mode});
    write_reg(gdt_pkg::CfgGrayInput, {7'($urandom), c.gray_input});
    if (poke_unused) begin
      write_reg(UnusedIndexA, 8'($urandom));
      write_reg(UnusedIndexB, 8'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [gdt_pkg::ChanW-1:0] rand_level();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 2) return gdt_pkg::ChanZero;
    if (pick < 4) return gdt_pkg::ChanMax;
    return 8'($urandom);
  endfunction

  function automatic gdt_pkg::cfg_t rand_cfg();
    gdt_pkg::cfg_t c;
    c.low_threshold   = rand_level();
    c.high_threshold  = rand_level();
    c.mark_low_color  = 1'($urandom);
    c.mark_high_color = 1'($urandom);
    c.preview_mode    = 1'($urandom);
    c.gray_input      = 1'($urandom);
    return c;
  endfunction

  // On gray input, levels are pulled toward the threshold edges in four of ten draws.
  function automatic gdt_pkg::in_word_t rand_pixel(gdt_pkg::cfg_t c);
    gdt_pkg::in_word_t         px;
    logic [gdt_pkg::ChanW-1:0] edge_level;
    px = 24'($urandom);
    if (c.gray_input && $urandom_range(9) < 4) begin
      edge_level = $urandom_range(1) ? c.low_threshold : c.high_threshold;
      px.in_blue = edge_level + 8'($urandom_range(2)) - 8'd1;
    end
    return px;
  endfunction

  initial begin
    gdt_pkg::cfg_t c;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: full range, color conversion, plain black and white.
    send_pixel(mk_px(gdt_pkg::ChanZero, gdt_pkg::ChanZero, gdt_pkg::ChanZero));
    send_pixel(mk_px(gdt_pkg::ChanMax, gdt_pkg::ChanMax, gdt_pkg::ChanMax));
    send_pixel(mk_px(gdt_pkg::ChanMax, gdt_pkg::ChanZero, gdt_pkg::ChanZero));
    send_pixel(mk_px(gdt_pkg::ChanZero, gdt_pkg::ChanMax, gdt_pkg::ChanZero));
    send_pixel(mk_px(gdt_pkg::ChanZero, gdt_pkg::ChanZero, gdt_pkg::ChanMax));
    send_pixel(mk_px(8'd128, 8'd64, 8'd200));
    drain();

    // Reversed thresholds with both colors marked on gray input.
    c = '{low_threshold: 8'd100, high_threshold: 8'd50, default: 1'b1};
    apply_cfg(c, 1'b1);
    send_pixel(mk_px(8'd0, 8'($urandom), 8'($urandom)));
    send_pixel(mk_px(8'd50, 8'($urandom), 8'($urandom)));
    send_pixel(mk_px(8'd51, 8'($urandom), 8'($urandom)));
    send_pixel(mk_px(8'd99, 8'($urandom), 8'($urandom)));
    send_pixel(mk_px(8'd100, 8'($urandom), 8'($urandom)));
    send_pixel(mk_px(8'd255, 8'($urandom), 8'($urandom)));
    drain();

    // Equal thresholds, marking bits set but preview off.
    c = '{low_threshold: 8'd77, high_threshold: 8'd77, default: 1'b1};
    c.preview_mode = 1'b0;
    apply_cfg(c, 1'b0);
    send_pixel(mk_px(8'd76, 8'($urandom), 8'($urandom)));
    send_pixel(mk_px(8'd77, 8'($urandom), 8'($urandom)));
    send_pixel(mk_px(8'd78, 8'($urandom), 8'($urandom)));
    drain();

    // Equal thresholds in preview: a level on both limits is painted low.
    c.preview_mode = 1'b1;
    apply_cfg(c, 1'b1);
    send_pixel(mk_px(8'd76, 8'($urandom), 8'($urandom)));
    send_pixel(mk_px(8'd77, 8'($urandom), 8'($urandom)));
    send_pixel(mk_px(8'd78, 8'($urandom), 8'($urandom)));
    c.gray_input = 1'b0;
    c.low_threshold = gdt_pkg::ChanMax;
    c.high_threshold = gdt_pkg::ChanZero;
    drain();
    apply_cfg(c, 1'b0);
    send_pixel(mk_px(gdt_pkg::ChanMax, gdt_pkg::ChanMax, gdt_pkg::ChanMax));
    send_pixel(mk_px(gdt_pkg::ChanZero, gdt_pkg::ChanZero, gdt_pkg::ChanZero));
    send_pixel(mk_px(8'd90, 8'd140, 8'd30));

    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin
          src_idle_pct = 28;
          dst_stall_pct = 59;
        end
        1: begin
          src_idle_pct = 59;
          dst_stall_pct = 28;
        end
        default: begin
          src_idle_pct = 0;
          dst_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SegmentCount; seg++) begin
        drain();
        c = rand_cfg();
        apply_cfg(c, $urandom_range(3) == 0);
        for (int n = 0; n < SegmentWords; n++) begin
          send_pixel(rand_pixel(c));
        end
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
